// ===== hw/rtl/sorted_alarm_timer_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted alarm timer queue
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_ALARM_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH

// holds at every clock edge outside reset
`define SATQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SATQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SATQ_ASSERT(lbl, clk, rstn, prop, msg)
`define SATQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/satq_pkg.sv =====
// ----------------------------------------------------------------------------
// satq_pkg
// Types, constants and helpers shared by the sorted alarm timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package satq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int N_W         = $clog2(MAX_RESULTS + 1);

    localparam int TIME_W  = 32;
    localparam int DELAY_W = 20;
    localparam int TAG_W   = 8;

    localparam logic [TIME_W-1:0] EMPTY_WAKE_DELAY = 32'd1000;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        KIND_INS_OK   = 2'd0,
        KIND_INS_FULL = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_NONE     = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_EV,
        ST_INS_WR,
        ST_HEAD_RD,
        ST_HEAD_EV,
        ST_CHK_EV
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        result_kind_t       kind;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  wake;
        logic               last;
    } result_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // circular buffer slot of a logical position
    function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/satq_req_if.sv =====
// ----------------------------------------------------------------------------
// satq_req_if
// Request channel: insert or time-check beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface satq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [satq_pkg::TIME_W-1:0]   now_time;
    logic [satq_pkg::DELAY_W-1:0]  delay_seconds;
    logic [satq_pkg::TAG_W-1:0]    alarm_tag;

    modport source (output valid, req_type, now_time, delay_seconds, alarm_tag,
                    input ready);
    modport sink   (input valid, req_type, now_time, delay_seconds, alarm_tag,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/satq_res_if.sv =====
// ----------------------------------------------------------------------------
// satq_res_if
// Result channel: one beat per result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface satq_res_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_kind;
    logic [satq_pkg::TAG_W-1:0]    expired_tag;
    logic [satq_pkg::DELAY_W-1:0]  expired_delay;
    logic [satq_pkg::TIME_W-1:0]   next_wake;
    logic                          is_last;

    modport source (output valid, result_kind, expired_tag, expired_delay,
                    next_wake, is_last, input ready);
    modport sink   (input valid, result_kind, expired_tag, expired_delay,
                    next_wake, is_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/satq_store.sv =====
// ----------------------------------------------------------------------------
// satq_store
// Alarm entry memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module satq_store (
    input  wire logic               clk,
    input  wire satq_pkg::mem_req_t mem_req,
    output satq_pkg::entry_t        rd_data
);

    satq_pkg::entry_t store_reg [satq_pkg::QUEUE_DEPTH];
    satq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            store_reg[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= store_reg[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/satq_ctrl.sv =====
// ----------------------------------------------------------------------------
// satq_ctrl
// Sequencer: sorted insert walk from the tail, expiry pops from the head.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_alarm_timer_queue_unit_assert.svh"

module satq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    satq_req_if.sink                req,
    output satq_pkg::mem_req_t      mem_req,
    input  wire satq_pkg::entry_t   rd_data,
    output logic                    emit_valid,
    output satq_pkg::result_t       emit,
    input  wire logic               emit_ready
);

    localparam int IDX_W = satq_pkg::IDX_W;
    localparam int CNT_W = satq_pkg::CNT_W;
    localparam int N_W   = satq_pkg::N_W;

    satq_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [N_W-1:0]    n_reg;
    logic              pend_reg;
    satq_pkg::result_kind_t kind_reg;

    logic [satq_pkg::TIME_W-1:0]  now_reg;
    logic [satq_pkg::TIME_W-1:0]  dl_reg;
    logic [satq_pkg::DELAY_W-1:0] delay_reg;
    logic [satq_pkg::TAG_W-1:0]   tag_reg;
    logic [satq_pkg::DELAY_W-1:0] pdelay_reg;
    logic [satq_pkg::TAG_W-1:0]   ptag_reg;

    logic              accept;
    logic              full;
    logic              nonempty;
    logic [CNT_W-1:0]  cnt_m1;
    logic              shift;
    logic              due;
    logic              need_emit;
    logic              go;
    logic              pop;
    logic [satq_pkg::TIME_W-1:0] wake;

    assign req.ready = (state_reg == satq_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(satq_pkg::QUEUE_DEPTH));
    assign nonempty  = (count_reg != '0);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign shift     = (rd_data.deadline > dl_reg);
    assign due       = nonempty && (rd_data.deadline <= now_reg)
                       && (n_reg < N_W'(satq_pkg::MAX_RESULTS));
    assign wake      = nonempty ? rd_data.deadline
                                : satq_pkg::sat_add(now_reg, satq_pkg::EMPTY_WAKE_DELAY);
    assign need_emit = pend_reg || !due;
    assign go        = !need_emit || emit_ready;
    assign pop       = (state_reg == satq_pkg::ST_CHK_EV) && go && due;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            satq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == satq_pkg::REQ_CHECK)
                    begin
                        state_next = satq_pkg::ST_CHK_EV;
                    end
                    else if (full)
                    begin
                        state_next = satq_pkg::ST_HEAD_EV;
                    end
                    else if (!nonempty)
                    begin
                        state_next = satq_pkg::ST_INS_WR;
                    end
                    else
                    begin
                        state_next = satq_pkg::ST_INS_EV;
                    end
                end
            end
            satq_pkg::ST_INS_EV:
            begin
                if (!shift || (idx_reg == IDX_W'(1)))
                begin
                    state_next = satq_pkg::ST_INS_WR;
                end
            end
            satq_pkg::ST_INS_WR:  state_next = satq_pkg::ST_HEAD_RD;
            satq_pkg::ST_HEAD_RD: state_next = satq_pkg::ST_HEAD_EV;
            satq_pkg::ST_HEAD_EV:
            begin
                if (emit_ready)
                begin
                    state_next = satq_pkg::ST_IDLE;
                end
            end
            satq_pkg::ST_CHK_EV:
            begin
                if (go && !due)
                begin
                    state_next = satq_pkg::ST_IDLE;
                end
            end
            default: state_next = satq_pkg::ST_IDLE;
        endcase
    end

    // memory requests and result beats
    always_comb
    begin
        mem_req    = '0;
        emit_valid = 1'b0;
        emit       = '0;
        unique case (state_reg)
            satq_pkg::ST_IDLE:
            begin
                mem_req.rd_en = accept;
                if ((req.req_type == satq_pkg::REQ_CHECK) || full)
                begin
                    mem_req.rd_addr = head_reg;
                end
                else
                begin
                    mem_req.rd_addr = satq_pkg::phys_idx(head_reg, cnt_m1[IDX_W-1:0]);
                end
            end
            satq_pkg::ST_INS_EV:
            begin
                if (shift)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = satq_pkg::phys_idx(head_reg, idx_reg);
                    mem_req.wr_data = rd_data;
                    if (idx_reg != IDX_W'(1))
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = satq_pkg::phys_idx(head_reg,
                                                             idx_reg - IDX_W'(2));
                    end
                end
            end
            satq_pkg::ST_INS_WR:
            begin
                mem_req.wr_en            = 1'b1;
                mem_req.wr_addr          = satq_pkg::phys_idx(head_reg, idx_reg);
                mem_req.wr_data.deadline = dl_reg;
                mem_req.wr_data.delay    = delay_reg;
                mem_req.wr_data.tag      = tag_reg;
            end
            satq_pkg::ST_HEAD_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = head_reg;
            end
            satq_pkg::ST_HEAD_EV:
            begin
                emit_valid = 1'b1;
                emit.kind  = kind_reg;
                emit.wake  = rd_data.deadline;
                emit.last  = 1'b1;
            end
            satq_pkg::ST_CHK_EV:
            begin
                emit_valid = need_emit;
                emit.wake  = wake;
                if (pend_reg)
                begin
                    emit.kind  = satq_pkg::KIND_EXPIRED;
                    emit.tag   = ptag_reg;
                    emit.delay = pdelay_reg;
                    emit.last  = !due;
                end
                else
                begin
                    emit.kind = satq_pkg::KIND_NONE;
                    emit.last = 1'b1;
                end
                if (pop)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = satq_pkg::phys_idx(head_reg, IDX_W'(1));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= satq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == satq_pkg::ST_INS_WR)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop)
            begin
                count_reg <= cnt_m1;
                head_reg  <= satq_pkg::phys_idx(head_reg, IDX_W'(1));
            end
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= req.now_time;
            dl_reg    <= satq_pkg::sat_add(req.now_time,
                                           satq_pkg::TIME_W'(req.delay_seconds));
            delay_reg <= req.delay_seconds;
            tag_reg   <= req.alarm_tag;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            idx_reg   <= count_reg[IDX_W-1:0];
            kind_reg  <= full ? satq_pkg::KIND_INS_FULL : satq_pkg::KIND_INS_OK;
        end
        else if ((state_reg == satq_pkg::ST_INS_EV) && shift)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        else if (pop)
        begin
            pend_reg   <= 1'b1;
            ptag_reg   <= rd_data.tag;
            pdelay_reg <= rd_data.delay;
            n_reg      <= n_reg + N_W'(1);
        end
    end

    `SATQ_ASSERT(a_count_range, clk, rst_n,
        count_reg <= CNT_W'(satq_pkg::QUEUE_DEPTH), "entry count beyond depth")
    `SATQ_ASSERT(a_head_valid, clk, rst_n,
        (state_reg != satq_pkg::ST_HEAD_EV) || nonempty, "wake read from empty queue")
    `SATQ_ASSERT(a_no_rw_clash, clk, rst_n,
        !(mem_req.wr_en && mem_req.rd_en && (mem_req.wr_addr == mem_req.rd_addr)),
        "read and write of the same slot")
    `SATQ_ASSERT_NEXT(a_pop_count, clk, rst_n, pop,
        count_reg == $past(count_reg) - CNT_W'(1), "pop did not shrink the queue")
    `SATQ_ASSERT(a_pop_limit, clk, rst_n,
        !pop || (n_reg < N_W'(satq_pkg::MAX_RESULTS)), "too many pops in one check")

endmodule

`default_nettype wire

// ===== hw/rtl/satq_out.sv =====
// ----------------------------------------------------------------------------
// satq_out
// Result output register; frees the sequencer from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module satq_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              emit_valid,
    input  wire satq_pkg::result_t emit,
    output logic                   emit_ready,
    satq_res_if.source             res
);

    logic              valid_reg;
    satq_pkg::result_t data_reg;

    assign emit_ready = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit_valid)
        begin
            data_reg <= emit;
        end
    end

    assign res.valid         = valid_reg;
    assign res.result_kind   = data_reg.kind;
    assign res.expired_tag   = data_reg.tag;
    assign res.expired_delay = data_reg.delay;
    assign res.next_wake     = data_reg.wake;
    assign res.is_last       = data_reg.last;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_alarm_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_unit
// Deadline-sorted alarm queue in a circular entry memory.
//
//   channel    dir  beat
//   alarm_req  in   req_type, now_time, delay_seconds, alarm_tag
//   alarm_res  out  result_kind, expired_tag, expired_delay, next_wake, is_last
//
// Insert: a walk from the tail shifts later entries up one slot, then the new
// entry is written and the head re-read; a dropped insert on a full queue
// only reads the head. Time check: expired alarms pop from the head in turn;
// one memory read port sets the pace. Result back-pressure stretches both.
// Reset clears the pointers only; the entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_alarm_timer_queue_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    satq_req_if.sink   alarm_req,
    satq_res_if.source alarm_res
);

    satq_pkg::mem_req_t mem_req;
    satq_pkg::entry_t   rd_data;
    satq_pkg::result_t  emit;
    logic               emit_valid;
    logic               emit_ready;

    satq_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    satq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (alarm_req),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_ready (emit_ready)
    );

    satq_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_ready (emit_ready),
        .res        (alarm_res)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the sorted alarm timer queue. A tracker keeps its own sorted copy
// of the alarm queue, works out the result beats of every accepted request
// and checks each result beat in order. A directed run covers the empty,
// full and saturating cases. Random traffic then follows on a wandering
// clock, with random gaps on both channels and a drain in between.
// ----------------------------------------------------------------------------
module tb_top;
    import satq_pkg::*;

    typedef struct {
        result_kind_t       kind;
        bit [TAG_W-1:0]     tag;
        bit [DELAY_W-1:0]   delay;
        bit [TIME_W-1:0]    wake;
        bit                 last;
    } alarm_result_t;

    class alarm_queue_tracker;
        bit [TIME_W-1:0]   deadline_q [QUEUE_DEPTH];
        bit [TAG_W-1:0]    tag_q      [QUEUE_DEPTH];
        bit [DELAY_W-1:0]  delay_q    [QUEUE_DEPTH];
        int unsigned       fill;
        alarm_result_t     awaited [$];
        int unsigned       errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function bit [TIME_W-1:0] clamp_add(bit [TIME_W-1:0] a, bit [TIME_W-1:0] b);
            bit [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
        endfunction

        function bit [TIME_W-1:0] wake_at(bit [TIME_W-1:0] now);
            if (fill > 0)
            begin
                return deadline_q[0];
            end
            return clamp_add(now, EMPTY_WAKE_DELAY);
        endfunction

        function void push_result(result_kind_t kind, bit [TAG_W-1:0] tag,
                                  bit [DELAY_W-1:0] delay, bit [TIME_W-1:0] now,
                                  bit last);
            alarm_result_t r;
            r.kind  = kind;
            r.tag   = tag;
            r.delay = delay;
            r.wake  = wake_at(now);
            r.last  = last;
            awaited.push_back(r);
        endfunction

        function void note_request(bit req, bit [TIME_W-1:0] now,
                                   bit [DELAY_W-1:0] delay, bit [TAG_W-1:0] tag);
            bit [TIME_W-1:0]   dl;
            bit [TAG_W-1:0]    t;
            bit [DELAY_W-1:0]  d;
            int unsigned       pos;
            int unsigned       due;
            if (req == REQ_INSERT)
            begin
                if (fill >= QUEUE_DEPTH)
                begin
                    push_result(KIND_INS_FULL, '0, '0, now, 1'b1);
                    return;
                end
                dl  = clamp_add(now, {{(TIME_W-DELAY_W){1'b0}}, delay});
                pos = 0;
                while (pos < fill && deadline_q[pos] <= dl)
                begin
                    pos++;
                end
                for (int i = fill; i > pos; i--)
                begin
                    deadline_q[i] = deadline_q[i-1];
                    tag_q[i]      = tag_q[i-1];
                    delay_q[i]    = delay_q[i-1];
                end
                deadline_q[pos] = dl;
                tag_q[pos]      = tag;
                delay_q[pos]    = delay;
                fill++;
                push_result(KIND_INS_OK, '0, '0, now, 1'b1);
            end
            else
            begin
                due = 0;
                while (due < fill && due < MAX_RESULTS && deadline_q[due] <= now)
                begin
                    due++;
                end
                if (due == 0)
                begin
                    push_result(KIND_NONE, '0, '0, now, 1'b1);
                    return;
                end
                for (int n = 0; n < due; n++)
                begin
                    t = tag_q[0];
                    d = delay_q[0];
                    for (int i = 1; i < fill; i++)
                    begin
                        deadline_q[i-1] = deadline_q[i];
                        tag_q[i-1]      = tag_q[i];
                        delay_q[i-1]    = delay_q[i];
                    end
                    fill--;
                    push_result(KIND_EXPIRED, t, d, now, n == due - 1);
                end
            end
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [TAG_W-1:0] tag,
                                   logic [DELAY_W-1:0] delay,
                                   logic [TIME_W-1:0] wake, logic last);
            alarm_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual kind %0h",
                         $time, kind);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(kind));
            compare_field("expired_tag", 32'(want.tag), 32'(tag));
            compare_field("expired_delay", 32'(want.delay), 32'(delay));
            compare_field("next_wake", want.wake, wake);
            compare_field("is_last", 32'(want.last), 32'(last));
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    bit [TIME_W-1:0] sim_clock;

    satq_req_if alarm_req();
    satq_res_if alarm_res();

    alarm_queue_tracker tracker = new;

    sorted_alarm_timer_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .alarm_req (alarm_req),
        .alarm_res (alarm_res)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("** sorted_alarm_timer_queue_unit: FAILED **");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    initial
    begin
        int unsigned stall;
        stall = 0;
        alarm_res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                alarm_res.ready <= 1'b0;
                stall--;
            end
            else
            begin
                alarm_res.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    stall = pick_gap() + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && alarm_res.valid && alarm_res.ready)
        begin
            tracker.check_result(alarm_res.result_kind, alarm_res.expired_tag,
                                 alarm_res.expired_delay, alarm_res.next_wake,
                                 alarm_res.is_last);
        end
    end

    task automatic send_beat(bit req, bit [TIME_W-1:0] now,
                             bit [DELAY_W-1:0] delay, bit [TAG_W-1:0] tag);
        bit taken;
        taken = 1'b0;
        @(negedge clk);
        alarm_req.valid         <= 1'b1;
        alarm_req.req_type      <= req;
        alarm_req.now_time      <= now;
        alarm_req.delay_seconds <= delay;
        alarm_req.alarm_tag     <= tag;
        while (!taken)
        begin
            @(posedge clk);
            taken = alarm_req.ready;
        end
        tracker.note_request(req, now, delay, tag);
    endtask

    task automatic idle_gap(int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            alarm_req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic issue(bit req, bit [TIME_W-1:0] now,
                         bit [DELAY_W-1:0] delay, bit [TAG_W-1:0] tag);
        send_beat(req, now, delay, tag);
        idle_gap(pick_gap());
    endtask

    task automatic drain_results();
        idle_gap(1);
        while (tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_directed();
        issue(REQ_CHECK, 32'd0, 20'h00000, 8'h00);
        issue(REQ_CHECK, 32'hFFFF_FFFF, 20'hFFFFF, 8'hFF);
        issue(REQ_INSERT, 32'hFFFF_FFF0, 20'hFFFFF, 8'hFF);
        issue(REQ_INSERT, 32'd0, 20'h00000, 8'h00);
        issue(REQ_INSERT, 32'd100, 20'd50, 8'h01);
        issue(REQ_INSERT, 32'd150, 20'd0, 8'h02);
        issue(REQ_INSERT, 32'd0, 20'hFFFFF, 8'h80);
        issue(REQ_CHECK, 32'd149, 20'h55555, 8'h5A);
        for (int i = 0; i < 12; i++)
        begin
            issue(REQ_INSERT, 32'd200, 20'(i * 10), 8'(8'h10 + i));
        end
        // queue is full here, so this one is dropped
        issue(REQ_INSERT, 32'd300, 20'd0, 8'hAA);
        issue(REQ_CHECK, 32'hFFFF_FFFF, 20'hAAAAA, 8'hA5);
        issue(REQ_CHECK, 32'd5, 20'h00000, 8'h00);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned done;
        int unsigned r;
        bit [DELAY_W-1:0] delay;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                sim_clock = $urandom();
            end
            else if (r < 4)
            begin
                sim_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            end
            if (r >= 4 && r < 8)
            begin
                // burst of inserts to fill the queue and hit the full case
                for (int k = 0; k < 18; k++)
                begin
                    issue(REQ_INSERT, sim_clock, 20'($urandom_range(0, 500)),
                          8'($urandom_range(0, 255)));
                end
                done += 18;
            end
            else if (r < 58)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    delay = 20'($urandom_range(0, 300));
                end
                else if (r < 9)
                begin
                    delay = 20'($urandom_range(0, 20'hFFFFF));
                end
                else
                begin
                    delay = '0;
                end
                issue(REQ_INSERT, sim_clock, delay, 8'($urandom_range(0, 255)));
                done++;
            end
            else
            begin
                sim_clock = sim_clock + $urandom_range(0, 150);
                if (r > 95)
                begin
                    issue(REQ_CHECK, $urandom(), 20'($urandom()), 8'($urandom()));
                end
                else
                begin
                    issue(REQ_CHECK, sim_clock, 20'($urandom()), 8'($urandom()));
                end
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        calm                    = 1'b0;
        sim_clock               = 32'd1000;
        alarm_req.valid         = 1'b0;
        alarm_req.req_type      = REQ_INSERT;
        alarm_req.now_time      = '0;
        alarm_req.delay_seconds = '0;
        alarm_req.alarm_tag     = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        drain_results();
        run_random(100);
        // sender holds off until every result beat is back
        drain_results();
        calm = 1'b1;
        run_random(60);
        calm = 1'b0;
        run_random(110);

        drain_results();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
        begin
            $display("** sorted_alarm_timer_queue_unit: PASSED **");
        end
        else
        begin
            $display("** sorted_alarm_timer_queue_unit: FAILED **");
        end
        $finish;
    end
endmodule
